FILE: sv/aho_pkg.sv
// ----------------------------------------------------------------------------
// aho_pkg
// Shared types, operation codes and controller command codes for the
// multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package aho_pkg;

  localparam int DEF_NODES    = 256;
  localparam int DEF_ALPHABET = 256;

  // operation codes of an input item
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_SCAN     = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  // controller to datapath commands
  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP       = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LATCH     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_INS_CHK   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_INS_APL   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_SCN_CHK   = 5'd4;
  localparam logic [CMD_W-1:0] CMD_SCN_GOTO  = 5'd5;
  localparam logic [CMD_W-1:0] CMD_SCN_FAIL  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_SCN_END   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_FIN_INIT  = 5'd8;
  localparam logic [CMD_W-1:0] CMD_FIN_CHILD = 5'd9;
  localparam logic [CMD_W-1:0] CMD_FIN_VISIT = 5'd10;
  localparam logic [CMD_W-1:0] CMD_FIN_GOTO  = 5'd11;
  localparam logic [CMD_W-1:0] CMD_FIN_FAIL  = 5'd12;
  localparam logic [CMD_W-1:0] CMD_FIN_POP   = 5'd13;
  localparam logic [CMD_W-1:0] CMD_FIN_DEQ   = 5'd14;
  localparam logic [CMD_W-1:0] CMD_FIN_LINK  = 5'd15;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 5'd16;
  localparam logic [CMD_W-1:0] CMD_EMIT      = 5'd17;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
    logic       pattern_end;
  } aho_in_t;

  typedef struct packed {
    logic       match;
    logic [7:0] match_length;
    logic       status;
  } aho_out_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [1:0] op;
    logic       sym_ok;
    logic       ins_go;
    logic       gt_zero;
    logic       node_zero;
    logic       c_end;
    logic       q_empty;
    logic       clr_done;
    logic       out_free;
  } aho_stat_t;

endpackage

FILE: sv/aho_corasick_matcher.sv
// ----------------------------------------------------------------------------
// aho_corasick_matcher
// Multi-pattern byte matcher built on a trie with failure links.
// ----------------------------------------------------------------------------
// One item is worked at a time and every item returns one result. An insert
// skips its apply step when its pattern is being dropped. A scan follows
// failure links one hop at a time, since the goto and fail tables have one
// read port each. A finalize checks every symbol of each visited node,
// follows failure hops to set each child's failure link, queues the child
// and pops nodes from the breadth-first queue. After reset and on every clear
// item the goto table is swept one entry per cycle over NODES*ALPHABET entries
// (rounded up to powers of two), during which no item is taken. A finished
// result sits in the output register and the next item is taken while it
// waits. That next item's result is held, and no further item is taken,
// until the output register is free.
module aho_corasick_matcher
  import aho_pkg::*;
#(
  parameter int NODES    = DEF_NODES,
  parameter int ALPHABET = DEF_ALPHABET
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  aho_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output aho_out_t out_item
);

  logic [CMD_W-1:0] cmd;
  aho_stat_t        stat;

  // sequencer: one command per cycle
  aho_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, cursors and the result register
  aho_dp #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: sv/aho_ctrl.sv
// ----------------------------------------------------------------------------
// aho_ctrl
// Sequencer for insert, finalize, scan and clear items; issues one command
// per cycle to the datapath.
// ----------------------------------------------------------------------------
module aho_ctrl
  import aho_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  aho_stat_t        stat,
  output logic [CMD_W-1:0] cmd
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_DEC       = 5'd1;
  localparam logic [4:0] ST_INS_CHK   = 5'd2;
  localparam logic [4:0] ST_INS_APL   = 5'd3;
  localparam logic [4:0] ST_SCN_CHK   = 5'd4;
  localparam logic [4:0] ST_SCN_GOTO  = 5'd5;
  localparam logic [4:0] ST_SCN_FAIL  = 5'd6;
  localparam logic [4:0] ST_SCN_END   = 5'd7;
  localparam logic [4:0] ST_FIN_INIT  = 5'd8;
  localparam logic [4:0] ST_FIN_CHILD = 5'd9;
  localparam logic [4:0] ST_FIN_VISIT = 5'd10;
  localparam logic [4:0] ST_FIN_GOTO  = 5'd11;
  localparam logic [4:0] ST_FIN_FAIL  = 5'd12;
  localparam logic [4:0] ST_FIN_POP   = 5'd13;
  localparam logic [4:0] ST_FIN_DEQ   = 5'd14;
  localparam logic [4:0] ST_FIN_LINK  = 5'd15;
  localparam logic [4:0] ST_CLR       = 5'd16;
  localparam logic [4:0] ST_RST_CLR   = 5'd17;
  localparam logic [4:0] ST_DONE      = 5'd18;

  logic [4:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LATCH;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        case (stat.op)
          OP_INSERT:   state_nxt = ST_INS_CHK;
          OP_FINALIZE: state_nxt = ST_FIN_INIT;
          OP_SCAN:     state_nxt = ST_SCN_CHK;
          default:     state_nxt = ST_CLR;
        endcase
      end
      ST_INS_CHK: begin
        cmd       = CMD_INS_CHK;
        state_nxt = stat.ins_go ? ST_INS_APL : ST_DONE;
      end
      ST_INS_APL: begin
        cmd       = CMD_INS_APL;
        state_nxt = ST_DONE;
      end
      ST_SCN_CHK: begin
        cmd       = CMD_SCN_CHK;
        state_nxt = stat.sym_ok ? ST_SCN_GOTO : ST_DONE;
      end
      ST_SCN_GOTO: begin
        cmd       = CMD_SCN_GOTO;
        state_nxt = (stat.gt_zero && !stat.node_zero) ? ST_SCN_FAIL : ST_SCN_END;
      end
      ST_SCN_FAIL: begin
        cmd       = CMD_SCN_FAIL;
        state_nxt = ST_SCN_GOTO;
      end
      ST_SCN_END: begin
        cmd       = CMD_SCN_END;
        state_nxt = ST_DONE;
      end
      ST_FIN_INIT: begin
        cmd       = CMD_FIN_INIT;
        state_nxt = ST_FIN_CHILD;
      end
      ST_FIN_CHILD: begin
        cmd       = CMD_FIN_CHILD;
        state_nxt = stat.c_end ? ST_FIN_POP : ST_FIN_VISIT;
      end
      ST_FIN_VISIT: begin
        cmd       = CMD_FIN_VISIT;
        state_nxt = stat.gt_zero ? ST_FIN_CHILD : ST_FIN_GOTO;
      end
      ST_FIN_GOTO: begin
        cmd       = CMD_FIN_GOTO;
        state_nxt = (stat.gt_zero && !stat.node_zero) ? ST_FIN_FAIL : ST_FIN_CHILD;
      end
      ST_FIN_FAIL: begin
        cmd       = CMD_FIN_FAIL;
        state_nxt = ST_FIN_GOTO;
      end
      ST_FIN_POP: begin
        cmd       = CMD_FIN_POP;
        state_nxt = stat.q_empty ? ST_DONE : ST_FIN_DEQ;
      end
      ST_FIN_DEQ: begin
        cmd       = CMD_FIN_DEQ;
        state_nxt = ST_FIN_LINK;
      end
      ST_FIN_LINK: begin
        cmd       = CMD_FIN_LINK;
        state_nxt = ST_FIN_CHILD;
      end
      ST_CLR: begin
        cmd       = CMD_CLEAR;
        state_nxt = stat.clr_done ? ST_DONE : ST_CLR;
      end
      ST_RST_CLR: begin
        cmd       = CMD_CLEAR;
        state_nxt = stat.clr_done ? ST_IDLE : ST_RST_CLR;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd       = CMD_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/aho_dp.sv
// ----------------------------------------------------------------------------
// aho_dp
// Node tables, BFS queue, cursors and result register of the matcher.
// ----------------------------------------------------------------------------
module aho_dp
  import aho_pkg::*;
#(
  parameter int NODES    = DEF_NODES,
  parameter int ALPHABET = DEF_ALPHABET
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CMD_W-1:0] cmd,
  input  aho_in_t          in_item,
  output aho_stat_t        stat,
  output logic             out_valid,
  input  logic             out_stall,
  output aho_out_t         out_item
);

  localparam int NW  = $clog2(NODES);
  localparam int AW  = $clog2(ALPHABET);
  localparam int GAW = NW + AW;
  localparam logic [NW:0] NODES_C    = (NW+1)'(NODES);
  localparam logic [AW:0] ALPHABET_C = (AW+1)'(ALPHABET);
  localparam logic [8:0]  ALPHA_LIM  = 9'(ALPHABET);

  // tables
  logic [NW-1:0] goto_mem [2**GAW];
  logic [NW-1:0] fail_mem [2**NW];
  logic [7:0]    end_mem  [2**NW];
  logic [NW-1:0] q_mem    [2**NW];

  logic [NW-1:0] gt_q, fl_q, qu_q;
  logic [7:0]    el_q;

  // item and working registers
  logic [1:0]     op_r;
  logic [7:0]     sym_r;
  logic           last_r;
  logic [NW:0]    node_cnt_r, node_cnt_nxt;
  logic [NW-1:0]  ins_cur_r, ins_cur_nxt;
  logic [7:0]     ins_len_r, ins_len_nxt;
  logic           drop_r, drop_nxt;
  logic           full_r, full_nxt;
  logic [NW-1:0]  scan_cur_r, scan_cur_nxt;
  logic [NW-1:0]  node_r, node_nxt;
  logic [NW-1:0]  u_r, u_nxt;
  logic [NW-1:0]  fu_r, fu_nxt;
  logic [NW-1:0]  v_r, v_nxt;
  logic [AW:0]    c_r, c_nxt;
  logic [NW-1:0]  head_r, head_nxt;
  logic [NW-1:0]  tail_r, tail_nxt;
  logic [GAW-1:0] clr_r, clr_nxt;
  logic           res_match_r, res_match_nxt;
  logic [7:0]     res_len_r, res_len_nxt;
  logic           res_stat_r, res_stat_nxt;
  logic           out_valid_r;
  aho_out_t       out_r;

  // memory ports
  logic [GAW-1:0] gt_raddr, gt_waddr;
  logic [NW-1:0]  gt_wdata;
  logic           gt_we;
  logic [NW-1:0]  fl_raddr, fl_waddr, fl_wdata;
  logic           fl_we;
  logic [NW-1:0]  el_raddr, el_waddr;
  logic [7:0]     el_wdata;
  logic           el_we;
  logic [NW-1:0]  q_waddr, q_wdata;
  logic           q_we;

  logic [AW-1:0] sym_idx, c_idx;
  logic          sym_ok, gt_zero, full_tbl;
  logic [7:0]    len_inc;
  logic [NW-1:0] new_node;

  assign sym_idx  = sym_r[AW-1:0];
  assign c_idx    = c_r[AW-1:0];
  assign sym_ok   = ({1'b0, sym_r} < ALPHA_LIM);
  assign gt_zero  = (gt_q == '0);
  assign full_tbl = (node_cnt_r >= NODES_C);
  assign len_inc  = (ins_len_r == 8'hFF) ? ins_len_r : ins_len_r + 8'd1;
  assign new_node = gt_zero ? node_cnt_r[NW-1:0] : gt_q;

  assign stat.op        = op_r;
  assign stat.sym_ok    = sym_ok;
  assign stat.ins_go    = !drop_r && sym_ok;
  assign stat.gt_zero   = gt_zero;
  assign stat.node_zero = (node_r == '0);
  assign stat.c_end     = (c_r == ALPHABET_C);
  assign stat.q_empty   = (head_r == tail_r);
  assign stat.clr_done  = (clr_r == {GAW{1'b1}});
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // read address selection
  always_comb begin
    case (cmd)
      CMD_INS_CHK:   gt_raddr = {ins_cur_r, sym_idx};
      CMD_SCN_CHK:   gt_raddr = {scan_cur_r, sym_idx};
      CMD_SCN_FAIL:  gt_raddr = {fl_q, sym_idx};
      CMD_FIN_CHILD: gt_raddr = {u_r, c_idx};
      CMD_FIN_VISIT: gt_raddr = {fu_r, c_idx};
      CMD_FIN_FAIL:  gt_raddr = {fl_q, c_idx};
      default:       gt_raddr = {ins_cur_r, sym_idx};
    endcase
    case (cmd)
      CMD_FIN_DEQ: fl_raddr = qu_q;
      default:     fl_raddr = node_r;
    endcase
    el_raddr = gt_q;
  end

  always_comb begin
    node_cnt_nxt  = node_cnt_r;
    ins_cur_nxt   = ins_cur_r;
    ins_len_nxt   = ins_len_r;
    drop_nxt      = drop_r;
    full_nxt      = full_r;
    scan_cur_nxt  = scan_cur_r;
    node_nxt      = node_r;
    u_nxt         = u_r;
    fu_nxt        = fu_r;
    v_nxt         = v_r;
    c_nxt         = c_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    clr_nxt       = clr_r;
    res_match_nxt = res_match_r;
    res_len_nxt   = res_len_r;
    res_stat_nxt  = res_stat_r;
    gt_we = 1'b0; gt_waddr = {ins_cur_r, sym_idx}; gt_wdata = new_node;
    fl_we = 1'b0; fl_waddr = v_r; fl_wdata = '0;
    el_we = 1'b0; el_waddr = new_node; el_wdata = len_inc;
    q_we  = 1'b0; q_waddr = tail_r; q_wdata = v_r;
    case (cmd)
      CMD_LATCH: begin
        res_match_nxt = 1'b0;
        res_len_nxt   = 8'd0;
        res_stat_nxt  = 1'b0;
      end
      CMD_INS_CHK: begin
        if (drop_r) begin
          res_stat_nxt = full_r;
        end else if (!sym_ok) begin
          drop_nxt = 1'b1;
          full_nxt = 1'b0;
        end
        if ((drop_r || !sym_ok) && last_r) begin
          ins_cur_nxt = '0; ins_len_nxt = 8'd0; drop_nxt = 1'b0; full_nxt = 1'b0;
        end
      end
      CMD_INS_APL: begin
        if (gt_zero && full_tbl) begin
          drop_nxt     = 1'b1;
          full_nxt     = 1'b1;
          res_stat_nxt = 1'b1;
        end else begin
          if (gt_zero) begin
            node_cnt_nxt = node_cnt_r + 1'b1;
            gt_we        = 1'b1;
          end
          ins_cur_nxt = new_node;
          ins_len_nxt = len_inc;
          el_we       = last_r;
        end
        if (last_r) begin
          ins_cur_nxt = '0; ins_len_nxt = 8'd0; drop_nxt = 1'b0; full_nxt = 1'b0;
        end
      end
      CMD_SCN_CHK: begin
        node_nxt = scan_cur_r;
        if (!sym_ok) scan_cur_nxt = '0;
      end
      CMD_SCN_GOTO: begin
        // no edge and not at root: fetch the failure link instead
        if (!(gt_zero && node_r != '0)) node_nxt = gt_q;
      end
      CMD_SCN_FAIL: node_nxt = fl_q;
      CMD_SCN_END: begin
        if (el_q != 8'd0) begin
          res_match_nxt = 1'b1;
          res_len_nxt   = el_q;
          scan_cur_nxt  = '0;
        end else begin
          scan_cur_nxt = node_r;
        end
      end
      CMD_FIN_INIT: begin
        u_nxt = '0; fu_nxt = '0; c_nxt = '0;
        head_nxt = '0; tail_nxt = '0; scan_cur_nxt = '0;
      end
      CMD_FIN_VISIT: begin
        if (gt_zero) begin
          c_nxt = c_r + 1'b1;
        end else begin
          v_nxt    = gt_q;
          node_nxt = fu_r;
        end
      end
      CMD_FIN_GOTO: begin
        if (!(gt_zero && node_r != '0)) begin
          fl_we    = 1'b1;
          fl_wdata = (!gt_zero && gt_q != v_r) ? gt_q : '0;
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
          c_nxt    = c_r + 1'b1;
        end
      end
      CMD_FIN_FAIL: node_nxt = fl_q;
      CMD_FIN_POP: begin
        if (head_r != tail_r) head_nxt = head_r + 1'b1;
      end
      CMD_FIN_DEQ: u_nxt = qu_q;
      CMD_FIN_LINK: begin
        fu_nxt = fl_q;
        c_nxt  = '0;
      end
      CMD_CLEAR: begin
        gt_we = 1'b1; gt_waddr = clr_r; gt_wdata = '0;
        fl_we = 1'b1; fl_waddr = clr_r[NW-1:0]; fl_wdata = '0;
        el_we = 1'b1; el_waddr = clr_r[NW-1:0]; el_wdata = 8'd0;
        clr_nxt = clr_r + 1'b1;
        node_cnt_nxt = (NW+1)'(1);
        ins_cur_nxt = '0; ins_len_nxt = 8'd0; drop_nxt = 1'b0; full_nxt = 1'b0;
        scan_cur_nxt = '0;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (gt_we) goto_mem[gt_waddr] <= gt_wdata;
    gt_q <= goto_mem[gt_raddr];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fail_mem[fl_waddr] <= fl_wdata;
    fl_q <= fail_mem[fl_raddr];
  end

  always_ff @(posedge clk) begin
    if (el_we) end_mem[el_waddr] <= el_wdata;
    el_q <= end_mem[el_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    qu_q <= q_mem[head_r];
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      op_r   <= in_item.operation;
      sym_r  <= in_item.symbol;
      last_r <= in_item.pattern_end;
    end
    if (cmd == CMD_EMIT) begin
      out_r.match        <= res_match_r;
      out_r.match_length <= res_len_r;
      out_r.status       <= res_stat_r;
    end
    node_r      <= node_nxt;
    u_r         <= u_nxt;
    fu_r        <= fu_nxt;
    v_r         <= v_nxt;
    c_r         <= c_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    res_match_r <= res_match_nxt;
    res_len_r   <= res_len_nxt;
    res_stat_r  <= res_stat_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r  <= (NW+1)'(1);
      ins_cur_r   <= '0;
      ins_len_r   <= 8'd0;
      drop_r      <= 1'b0;
      full_r      <= 1'b0;
      scan_cur_r  <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      node_cnt_r <= node_cnt_nxt;
      ins_cur_r  <= ins_cur_nxt;
      ins_len_r  <= ins_len_nxt;
      drop_r     <= drop_nxt;
      full_r     <= full_nxt;
      scan_cur_r <= scan_cur_nxt;
      clr_r      <= clr_nxt;
      if (cmd == CMD_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule
